/* rtl/spq_pkg.sv */
// Shared types and constants for the strict priority packet queue.
package spq_pkg;

  localparam int MODE_W = 2;
  localparam int PRI_W  = 3;
  localparam int CODE_W = 3;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [MODE_W-1:0] MODE_GET  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXCH = 2'd2;

  localparam logic [CODE_W-1:0] RES_NONE    = 3'd0;
  localparam logic [CODE_W-1:0] RES_DONE    = 3'd1;
  localparam logic [CODE_W-1:0] RES_EVICTED = 3'd2;
  localparam logic [CODE_W-1:0] RES_SWAPPED = 3'd3;
  localparam logic [CODE_W-1:0] RES_BACK    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } cmd_t;

endpackage

/* rtl/spq_ram.sv */
// Generic single-write, single-read RAM with registered read (old data on collision).
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

/* rtl/spq_ctrl.sv */
// Controller: sequences accept, execute and respond, owns the output valid.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::cmd_t cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == spq_pkg::ST_IDLE) || (state == spq_pkg::ST_RESP && out_free);

  always_comb begin
    cmd.load_in  = in_valid && in_ready;
    cmd.exec     = (state == spq_pkg::ST_EXEC);
    cmd.load_out = (state == spq_pkg::ST_RESP) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        state_next = spq_pkg::ST_RESP;
      end
      spq_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = in_valid ? spq_pkg::ST_EXEC : spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/spq_dp.sv */
// Datapath: level pointers and fills, level search, handle store and result registers.
module spq_dp #(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  spq_pkg::cmd_t               cmd,
  input  logic                        cfg_valid,
  input  logic [spq_pkg::CNT_W-1:0]   cfg_data,
  input  logic [spq_pkg::MODE_W-1:0]  mode,
  input  logic [spq_pkg::PRI_W-1:0]   priority_req,
  input  logic [HANDLE_BITS-1:0]      handle_in,
  output logic [spq_pkg::CODE_W-1:0]  result_code,
  output logic [HANDLE_BITS-1:0]      handle_out,
  output logic [spq_pkg::CNT_W-1:0]   occupancy
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int DEPTH  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = spq_pkg::CNT_W;

  // level state
  logic [PTR_W-1:0]  head [NUM_LEVELS];
  logic [FILL_W-1:0] fill [NUM_LEVELS];
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  capacity;

  // captured request
  logic [spq_pkg::MODE_W-1:0] mode_r;
  logic [LVL_W-1:0]           prio_r;
  logic [HANDLE_BITS-1:0]     hin_r;
  logic [4:0]                 prio_ext;

  // execute decision
  logic [NUM_LEVELS-1:0]     nonempty;
  logic [NUM_LEVELS-1:0]     full;
  logic                      found_hi, found_lo, found_hx;
  logic [LVL_W-1:0]          hi_lvl, lo_lvl, hx_lvl;
  logic                      do_pop, do_push, tot_inc, tot_dec;
  logic [LVL_W-1:0]          pop_lvl;
  logic [spq_pkg::CODE_W-1:0] code;
  logic [HANDLE_BITS-1:0]    hback;
  logic [PTR_W-1:0]          pop_ptr, push_ptr;
  logic [PTR_W-1:0]          tail [NUM_LEVELS];
  logic [PTR_W-1:0]          head_inc [NUM_LEVELS];
  logic [ADDR_W-1:0]         pop_addr, push_addr;

  // results carried to the respond step
  logic                       pop_r;
  logic [spq_pkg::CODE_W-1:0] code_r;
  logic [HANDLE_BITS-1:0]     hback_r;
  logic [HANDLE_BITS-1:0]     rd_data;

  assign prio_ext = {2'b00, priority_req};

  // per-level tail slot and next head, each at its own level
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [PTR_W:0]   inc;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (fill[l] != '0);
      full[l]     = (fill[l] == FILL_W'(LEVEL_DEPTH));
      sum = SUM_W'(head[l]) + SUM_W'(fill[l]);
      if (sum >= SUM_W'(LEVEL_DEPTH)) begin
        sum = sum - SUM_W'(LEVEL_DEPTH);
      end
      tail[l] = PTR_W'(sum);
      inc = (PTR_W + 1)'(head[l]) + (PTR_W + 1)'(1);
      head_inc[l] = (inc == (PTR_W + 1)'(LEVEL_DEPTH)) ? '0 : PTR_W'(inc);
    end
  end

  // level searches
  always_comb begin
    found_hi = 1'b0;
    found_lo = 1'b0;
    found_hx = 1'b0;
    hi_lvl   = '0;
    lo_lvl   = '0;
    hx_lvl   = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (nonempty[l]) begin
        found_hi = 1'b1;
        hi_lvl   = LVL_W'(l);
      end
      if (nonempty[l] && LVL_W'(l) >= prio_r) begin
        found_hx = 1'b1;
        hx_lvl   = LVL_W'(l);
      end
    end
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (nonempty[l] && LVL_W'(l) <= prio_r) begin
        found_lo = 1'b1;
        lo_lvl   = LVL_W'(l);
      end
    end
  end

  always_comb begin
    do_pop  = 1'b0;
    do_push = 1'b0;
    tot_inc = 1'b0;
    tot_dec = 1'b0;
    pop_lvl = '0;
    code    = spq_pkg::RES_NONE;
    hback   = '0;
    unique case (mode_r)
      spq_pkg::MODE_GET: begin
        if (found_hi) begin
          do_pop  = 1'b1;
          pop_lvl = hi_lvl;
          tot_dec = 1'b1;
          code    = spq_pkg::RES_DONE;
        end
      end
      spq_pkg::MODE_PUT: begin
        if (total < capacity) begin
          if (!full[prio_r]) begin
            do_push = 1'b1;
            tot_inc = 1'b1;
            code    = spq_pkg::RES_DONE;
          end
        end else if (found_lo && (lo_lvl == prio_r || !full[prio_r])) begin
          do_pop  = 1'b1;
          do_push = 1'b1;
          pop_lvl = lo_lvl;
          code    = spq_pkg::RES_EVICTED;
        end
      end
      spq_pkg::MODE_EXCH: begin
        code  = spq_pkg::RES_BACK;
        hback = hin_r;
        if (total != '0 && found_hx && (hx_lvl == prio_r || !full[prio_r])) begin
          do_pop  = 1'b1;
          do_push = 1'b1;
          pop_lvl = hx_lvl;
          code    = spq_pkg::RES_SWAPPED;
          hback   = '0;
        end
      end
      default: begin
        code = spq_pkg::RES_NONE;
      end
    endcase
  end

  // one-hot selection of the slot pointers
  always_comb begin
    pop_ptr  = '0;
    push_ptr = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (pop_lvl == LVL_W'(l)) begin
        pop_ptr = pop_ptr | head[l];
      end
      if (prio_r == LVL_W'(l)) begin
        push_ptr = push_ptr | tail[l];
      end
    end
    pop_addr  = ADDR_W'(pop_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pop_ptr);
    push_addr = ADDR_W'(prio_r) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(push_ptr);
  end

  spq_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.exec && do_push),
    .wr_addr (push_addr),
    .wr_data (hin_r),
    .rd_en   (cmd.exec && do_pop),
    .rd_addr (pop_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head[l] <= '0;
        fill[l] <= '0;
      end
      total    <= '0;
      capacity <= spq_pkg::CAP_RESET;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (cmd.exec) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          if (do_pop && pop_lvl == LVL_W'(l)) begin
            head[l] <= head_inc[l];
          end
          if (do_pop && pop_lvl == LVL_W'(l) && !(do_push && prio_r == LVL_W'(l))) begin
            fill[l] <= fill[l] - FILL_W'(1);
          end else if (do_push && prio_r == LVL_W'(l)
                       && !(do_pop && pop_lvl == LVL_W'(l))) begin
            fill[l] <= fill[l] + FILL_W'(1);
          end
        end
        if (tot_inc) begin
          total <= total + CNT_W'(1);
        end else if (tot_dec) begin
          total <= total - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= mode;
      hin_r  <= handle_in;
      if (int'(priority_req) >= NUM_LEVELS) begin
        prio_r <= LVL_W'(NUM_LEVELS - 1);
      end else begin
        prio_r <= LVL_W'(prio_ext);
      end
    end
    if (cmd.exec) begin
      pop_r   <= do_pop;
      code_r  <= code;
      hback_r <= hback;
    end
    if (cmd.load_out) begin
      result_code <= code_r;
      handle_out  <= pop_r ? rd_data : hback_r;
      occupancy   <= total;
    end
  end

endmodule

/* rtl/strict_priority_packet_queue.sv */
// Top level of the strict priority packet queue.
//
// Input channel (in_valid/in_ready) carries mode, priority_req and handle_in:
// get takes the oldest handle of the highest non-empty level, put stores a
// handle (evicting the oldest of the lowest non-empty level at or below its
// priority when full), exchange swaps it for the oldest handle at an equal or
// higher level or hands it back. Every transfer yields exactly one result on
// the output channel (out_valid/out_ready): result_code, handle_out, occupancy.
// A write on cfg_valid/cfg_data sets total_capacity; cfg_ready is always high.
// The result is registered: the handle memory has a registered read (select
// and access in the execute step, result capture in the respond step). A new
// item is taken in in the respond step of the last one when the output is free.
// When the receiver stalls, the result waits in the output register and at
// most one more item is taken in; it is held until the result is taken.
// Reset (rst, synchronous) empties all levels and sets total_capacity to 64;
// the handle memory is not cleared, only filled slots are ever read.
module strict_priority_packet_queue #(
  parameter int NUM_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [spq_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [spq_pkg::MODE_W-1:0] mode,
  input  logic [spq_pkg::PRI_W-1:0]  priority_req,
  input  logic [HANDLE_BITS-1:0]     handle_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [spq_pkg::CODE_W-1:0] result_code,
  output logic [HANDLE_BITS-1:0]     handle_out,
  output logic [spq_pkg::CNT_W-1:0]  occupancy
);

  spq_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_dp #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .priority_req (priority_req),
    .handle_in    (handle_in),
    .result_code  (result_code),
    .handle_out   (handle_out),
    .occupancy    (occupancy)
  );

endmodule
